// ----- rtl/bm25_pkg.sv -----
package bm25_pkg;

  localparam int FRACTION_BITS_DEF  = 16;
  localparam int LOG_TABLE_BITS_DEF = 8;

  // round(ln 2 * 2^32)
  localparam logic [31:0] LN2_Q32 = 32'd2977044472;

  localparam logic [31:0] DOC_COUNT_RST = 32'd0;
  localparam logic [31:0] AVG_LEN_RST   = 32'd65536;
  localparam logic [15:0] K1_RST        = 16'd4915;
  localparam logic [12:0] B_RST         = 13'd3072;
  localparam logic [12:0] B_ONE         = 13'd4096;

  typedef enum logic [1:0] {
    CFG_DOC_COUNT = 2'd0,
    CFG_AVG_LEN   = 2'd1,
    CFG_K1        = 2'd2,
    CFG_B         = 2'd3
  } cfg_index_t;

  // log2(1 + i/2^tb) in Q0.fb, by repeated squaring of the mantissa
  function automatic logic [63:0] log_entry(int i, int fb, int tb);
    logic [63:0] m;
    logic [63:0] r;
    if (i >= (1 << tb)) begin
      return 64'd1 << fb;
    end
    m = (64'(1 << tb) + 64'(i)) << (30 - tb);
    r = 64'd0;
    for (int k = 0; k < fb; k++) begin
      m = (m * m) >> 30;
      r = r << 1;
      if (m >= 64'h8000_0000) begin
        r = r | 64'd1;
        m = m >> 1;
      end
    end
    return r;
  endfunction

endpackage

// ----- rtl/bm25_in_if.sv -----
interface bm25_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] term_count;
  logic [31:0] docs_with_term;
  logic [23:0] document_length;
  logic        last_term;

  modport source(output valid, term_count, docs_with_term, document_length, last_term,
                 input ready);
  modport sink(input valid, term_count, docs_with_term, document_length, last_term,
               output ready);
endinterface

// ----- rtl/bm25_out_if.sv -----
interface bm25_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] score;
  logic        score_saturated;

  modport source(output valid, score, score_saturated, input ready);
  modport sink(input valid, score, score_saturated, output ready);
endinterface

// ----- rtl/bm25_cfg_if.sv -----
interface bm25_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [31:0] data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

// ----- rtl/bm25_document_scorer_unit.sv -----
// BM25 document scorer.
// in_ch carries one query term per word: term count, document frequency,
// document length and a last-term flag. out_ch returns one word per
// document (score in unsigned Q16.16 and a saturation flag) after the word
// flagged last. cfg_ch writes N, average length, k1 and b by index; it is
// always ready and is meant to be written while the block is idle.
// Between accept and the next ready, a term goes through two logarithms on
// the log unit, then len/avglen and the tf fraction on the bit-serial
// divider, then the multiply, accumulate and hand-off steps.
// A saturated length ratio skips the first division, a zero denominator the
// second. The score word is registered in the accumulate step of the last term.
// in_ch.ready is high only between terms, so one term is in work at a time.
// A finished score waits in the output register while the next document's
// terms are taken; if it is still not taken when the next last term is done,
// the block holds that term until out_ch.ready.
// Synchronous active-low reset clears the accumulator, the output valid and
// loads the configuration defaults (N 0, avglen 1.0, k1 1.2, b 0.75).
module bm25_document_scorer_unit #(
  parameter int FRACTION_BITS  = bm25_pkg::FRACTION_BITS_DEF,
  parameter int LOG_TABLE_BITS = bm25_pkg::LOG_TABLE_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  bm25_in_if.sink    in_ch,
  bm25_out_if.source out_ch,
  bm25_cfg_if.sink   cfg_ch
);
  import bm25_pkg::*;

  localparam int F   = FRACTION_BITS;
  localparam int L2W = F + 7;
  localparam int RW  = 24 + F;
  localparam int IW  = RW + 2;
  localparam int NW  = IW + 4;
  localparam int VW  = RW + 7;
  localparam int QW  = RW;
  localparam int SW  = $clog2(QW + 1);
  localparam int TW  = L2W + 5;
  localparam int TMW = TW + 1;
  localparam int FRW = 21;

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_LOGN  = 10'b0000000010,
    S_LOGD  = 10'b0000000100,
    S_RATIO = 10'b0000001000,
    S_INNER = 10'b0000010000,
    S_NORM  = 10'b0000100000,
    S_DEN   = 10'b0001000000,
    S_FRAC  = 10'b0010000000,
    S_T     = 10'b0100000000,
    S_ACC   = 10'b1000000000
  } state_t;

  state_t          state_r;
  logic [31:0]     n_r;
  logic [31:0]     avg_r;
  logic [15:0]     k1_r;
  logic [12:0]     b_r;

  logic [15:0]     tf_r;
  logic [31:0]     df_r;
  logic [23:0]     len_r;
  logic            last_r;
  logic [L2W-1:0]  ln_num_r;
  logic [L2W-1:0]  idf_r;
  logic [RW-1:0]   ratio_r;
  logic [IW-1:0]   inner_r;
  logic [NW-1:0]   norm_r;
  logic [FRW-1:0]  frac_r;
  logic [TW-1:0]   t_r;
  logic            t_done_r;
  logic [39:0]     acc_r;
  logic            ovf_r;
  logic            out_valid_r;
  logic [31:0]     score_r;
  logic            sat_r;

  logic            in_accept;
  logic [31:0]     avg_eff;
  logic [12:0]     b_eff;
  logic            ratio_sat;
  logic [RW+12:0]  bprod;
  logic [RW+13:0]  inner_sum;
  logic [16+IW-1:0] norm_prod;
  logic [VW-1:0]   tfq;
  logic [VW-1:0]   den;
  logic [L2W+16:0] t_prod;
  logic [TW+20:0]  term_prod;
  logic [TMW-1:0]  term;
  logic [40:0]     acc_sum;
  logic [39:0]     acc_clip;
  logic            out_free;
  logic            out_load;

  logic            log_start;
  logic [33:0]     log_x;
  logic            log_done;
  logic [L2W-1:0]  log_ln;

  logic            div_start;
  logic [SW-1:0]   div_steps;
  logic [VW-1:0]   div_rem;
  logic [QW-1:0]   div_low;
  logic [VW-1:0]   div_dv;
  logic            div_done;
  logic [QW-1:0]   div_quot;

  assign in_accept = in_ch.valid && in_ch.ready;
  assign avg_eff   = (avg_r == 32'd0) ? 32'd1 : avg_r;
  assign b_eff     = (b_r > B_ONE) ? B_ONE : b_r;
  assign ratio_sat = {16'd0, len_r} >= {avg_eff, 8'd0};
  assign bprod     = (RW+13)'(b_eff) * (RW+13)'(ratio_r);
  assign inner_sum = ((RW+14)'(B_ONE - b_eff) << F) + (RW+14)'(bprod);
  assign norm_prod = (16+IW)'(k1_r) * (16+IW)'(inner_r);
  assign tfq       = VW'(tf_r) << F;
  assign den       = tfq + VW'(norm_r);
  assign t_prod    = (L2W+17)'(idf_r) * (L2W+17)'({1'b0, k1_r} + 17'd4096);
  assign term_prod = (TW+21)'(t_r) * (TW+21)'(frac_r);
  assign term      = term_prod[TW+20:20];
  assign acc_sum   = {1'b0, acc_r} + 41'(term);
  assign acc_clip  = acc_sum[40] ? {40{1'b1}} : acc_sum[39:0];
  assign out_free  = !out_valid_r || out_ch.ready;
  assign out_load  = (state_r == S_ACC) && last_r && out_free;

  assign log_start = (state_r == S_IDLE && in_accept) || (state_r == S_LOGN && log_done);
  assign log_x     = (state_r == S_IDLE) ? (34'({n_r, 1'b0}) + 34'd2)
                                         : {1'b0, df_r, 1'b1};

  assign div_start = (state_r == S_LOGD && log_done && !ratio_sat) ||
                     (state_r == S_DEN && den != '0);

  always_comb begin
    if (state_r == S_LOGD) begin
      div_steps = SW'(QW);
      div_rem   = VW'(len_r[23:8]);
      div_low   = {len_r[7:0], (16+F)'(0)};
      div_dv    = VW'(avg_eff);
    end else begin
      div_steps = SW'(FRW);
      div_rem   = tfq >> 1;
      div_low   = '0;
      div_dv    = den;
    end
  end

  bm25_log #(
    .FRACTION_BITS  (FRACTION_BITS),
    .LOG_TABLE_BITS (LOG_TABLE_BITS)
  ) u_log (
    .clk   (clk),
    .rst_n (rst_n),
    .start (log_start),
    .x     (log_x),
    .done  (log_done),
    .ln    (log_ln)
  );

  bm25_div #(
    .QW (QW),
    .VW (VW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .steps    (div_steps),
    .rem_init (div_rem),
    .low      (div_low),
    .divisor  (div_dv),
    .done     (div_done),
    .quot     (div_quot)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n_r   <= DOC_COUNT_RST;
      avg_r <= AVG_LEN_RST;
      k1_r  <= K1_RST;
      b_r   <= B_RST;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        CFG_DOC_COUNT: n_r   <= cfg_ch.data;
        CFG_AVG_LEN:   avg_r <= cfg_ch.data;
        CFG_K1:        k1_r  <= cfg_ch.data[15:0];
        CFG_B:         b_r   <= cfg_ch.data[12:0];
        default:       n_r   <= n_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      acc_r       <= 40'd0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
      t_done_r    <= 1'b0;
    end else begin
      if (out_valid_r && out_ch.ready && !out_load) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_accept) begin
            tf_r    <= in_ch.term_count;
            df_r    <= in_ch.docs_with_term;
            len_r   <= in_ch.document_length;
            last_r  <= in_ch.last_term;
            state_r <= S_LOGN;
          end
        end
        S_LOGN: begin
          if (log_done) begin
            ln_num_r <= log_ln;
            state_r  <= S_LOGD;
          end
        end
        S_LOGD: begin
          if (log_done) begin
            // a term more common than the collection adds nothing
            idf_r <= (ln_num_r > log_ln) ? (ln_num_r - log_ln) : '0;
            if (ratio_sat) begin
              ratio_r <= {RW{1'b1}};
              state_r <= S_INNER;
            end else begin
              state_r <= S_RATIO;
            end
          end
        end
        S_RATIO: begin
          if (div_done) begin
            ratio_r <= div_quot;
            state_r <= S_INNER;
          end
        end
        S_INNER: begin
          inner_r <= inner_sum[RW+13:12];
          state_r <= S_NORM;
        end
        S_NORM: begin
          norm_r  <= norm_prod[16+IW-1:12];
          state_r <= S_DEN;
        end
        S_DEN: begin
          if (den == '0) begin
            frac_r  <= '0;
            state_r <= S_T;
          end else begin
            state_r <= S_FRAC;
          end
        end
        S_FRAC: begin
          if (div_done) begin
            frac_r  <= div_quot[FRW-1:0];
            state_r <= S_T;
          end
        end
        S_T: begin
          t_r      <= t_prod[L2W+16:12];
          t_done_r <= 1'b1;
          state_r  <= S_ACC;
        end
        S_ACC: begin
          if (!last_r) begin
            acc_r    <= acc_clip;
            ovf_r    <= ovf_r | acc_sum[40];
            t_done_r <= 1'b0;
            state_r  <= S_IDLE;
          end else if (out_free) begin
            out_valid_r <= 1'b1;
            if (acc_clip > 40'h00_FFFF_FFFF) begin
              score_r <= 32'hFFFF_FFFF;
              sat_r   <= 1'b1;
            end else begin
              score_r <= acc_clip[31:0];
              sat_r   <= ovf_r | acc_sum[40];
            end
            acc_r    <= 40'd0;
            ovf_r    <= 1'b0;
            t_done_r <= 1'b0;
            state_r  <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_ch.ready            = (state_r == S_IDLE);
  assign cfg_ch.ready           = 1'b1;
  assign out_ch.valid           = out_valid_r;
  assign out_ch.score           = score_r;
  assign out_ch.score_saturated = sat_r;

`ifndef ASSERT_OFF
  a_acc_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ACC && !last_r) |=> (acc_r >= $past(acc_r)))
    else $error("accumulator decreased on a non-last term");

  a_div_owner: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == S_RATIO || state_r == S_FRAC))
    else $error("divider finished outside a divide step");

  a_log_owner: assert property (@(posedge clk) disable iff (!rst_n)
    log_done |-> (state_r == S_LOGN || state_r == S_LOGD))
    else $error("log unit finished outside a log step");

  a_hold_last: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ACC && last_r && out_valid_r && !out_ch.ready) |=> (state_r == S_ACC))
    else $error("last term dropped while output stalled");

  a_term_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ACC) |-> t_done_r)
    else $error("accumulate step reached without term product");
`endif

endmodule

// ----- rtl/bm25_log.sv -----
module bm25_log #(
  parameter int FRACTION_BITS  = bm25_pkg::FRACTION_BITS_DEF,
  parameter int LOG_TABLE_BITS = bm25_pkg::LOG_TABLE_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic [33:0]              x,
  output logic                     done,
  output logic [FRACTION_BITS+6:0] ln
);
  import bm25_pkg::*;

  localparam int F   = FRACTION_BITS;
  localparam int T   = LOG_TABLE_BITS;
  localparam int TN  = 1 << T;
  localparam int EW  = F + 1;
  localparam int SH  = 32 - T;
  localparam int L2W = F + 7;
  localparam int PW  = EW + SH;

  typedef enum logic [4:0] {
    L_IDLE = 5'b00001,
    L_NORM = 5'b00010,
    L_MUL  = 5'b00100,
    L_SUM  = 5'b01000,
    L_LN   = 5'b10000
  } lstate_t;

  lstate_t          st_r;
  logic [33:0]      xn_r;
  logic [5:0]       lz_r;
  logic [2:0]       step_r;
  logic [PW-1:0]    prod_r;
  logic [EW-1:0]    lo_r;
  logic [L2W-1:0]   log2_r;
  logic [L2W-1:0]   ln_r;
  logic             done_r;

  logic [EW-1:0]    tbl [TN+1];
  logic [5:0]       sh;
  logic             top_zero;
  logic [31:0]      f32;
  logic [T-1:0]     idx;
  logic [SH-1:0]    rem;
  logic [EW-1:0]    lo;
  logic [EW-1:0]    hi;
  logic [5:0]       e;
  logic [L2W+31:0]  lnp;

  for (genvar gi = 0; gi <= TN; gi++) begin : g_tbl
    assign tbl[gi] = EW'(log_entry(gi, F, T));
  end

  assign sh       = 6'd32 >> step_r;
  assign top_zero = (xn_r >> (6'd34 - sh)) == 34'd0;
  assign f32      = xn_r[32:1];
  assign idx      = f32[31 -: T];
  assign rem      = f32[SH-1:0];
  assign lo       = tbl[{1'b0, idx}];
  assign hi       = tbl[{1'b0, idx} + (T+1)'(1)];
  assign e        = 6'd33 - lz_r;
  assign lnp      = (L2W+32)'(log2_r) * (L2W+32)'(LN2_Q32) + (L2W+32)'(64'h8000_0000);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= L_IDLE;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      unique case (st_r)
        L_IDLE: begin
          if (start) begin
            xn_r   <= (x == 34'd0) ? 34'd1 : x;
            lz_r   <= 6'd0;
            step_r <= 3'd0;
            st_r   <= L_NORM;
          end
        end
        L_NORM: begin
          // binary search for the leading one, msb lands on bit 33
          if (top_zero) begin
            xn_r <= xn_r << sh;
            lz_r <= lz_r + sh;
          end
          step_r <= step_r + 3'd1;
          if (step_r == 3'd5) begin
            st_r <= L_MUL;
          end
        end
        L_MUL: begin
          prod_r <= PW'(hi - lo) * PW'(rem);
          lo_r   <= lo;
          st_r   <= L_SUM;
        end
        L_SUM: begin
          log2_r <= (L2W'(e) << F) + L2W'(lo_r) + L2W'(prod_r >> SH);
          st_r   <= L_LN;
        end
        L_LN: begin
          ln_r   <= lnp[L2W+31:32];
          done_r <= 1'b1;
          st_r   <= L_IDLE;
        end
        default: st_r <= L_IDLE;
      endcase
    end
  end

  assign done = done_r;
  assign ln   = ln_r;

endmodule

// ----- rtl/bm25_div.sv -----
module bm25_div #(
  parameter int QW = 40,
  parameter int VW = 47
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic [$clog2(QW+1)-1:0]  steps,
  input  logic [VW-1:0]            rem_init,
  input  logic [QW-1:0]            low,
  input  logic [VW-1:0]            divisor,
  output logic                     done,
  output logic [QW-1:0]            quot
);
  localparam int SW = $clog2(QW + 1);

  logic          busy_r;
  logic          done_r;
  logic [SW-1:0] cnt_r;
  logic [VW-1:0] rem_r;
  logic [QW-1:0] low_r;
  logic [QW-1:0] quot_r;
  logic [VW-1:0] dv_r;

  logic [VW:0]   trial;
  logic [VW:0]   diff;
  logic          fits;

  assign trial = {rem_r, low_r[QW-1]};
  assign fits  = trial >= {1'b0, dv_r};
  assign diff  = trial - {1'b0, dv_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        rem_r  <= rem_init;
        low_r  <= low;
        dv_r   <= divisor;
        quot_r <= '0;
        cnt_r  <= steps;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        // one restoring step: shift in a dividend bit, subtract if it fits
        rem_r  <= fits ? diff[VW-1:0] : trial[VW-1:0];
        low_r  <= low_r << 1;
        quot_r <= {quot_r[QW-2:0], fits};
        cnt_r  <= cnt_r - SW'(1);
        if (cnt_r == SW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign quot = quot_r;

endmodule

// ----- verif/bm25_document_scorer_unit_test.sv -----
`timescale 1ns / 1ps

module bm25_document_scorer_unit_test;
  import bm25_pkg::*;

  localparam int FB = 16;
  localparam int TB = 8;
  localparam logic [63:0] ACC_TOP = (64'd1 << 40) - 64'd1;
  localparam logic [63:0] RATIO_TOP = (64'd1 << (24 + FB)) - 64'd1;

  typedef struct {
    logic [15:0] tf;
    logic [31:0] df;
    logic [23:0] len;
    logic        last;
  } term_t;

  typedef struct {
    logic [31:0] score;
    logic        sat;
  } doc_score_t;

  logic clk;
  logic rst_n;

  bm25_in_if  in_ch();
  bm25_out_if out_ch();
  bm25_cfg_if cfg_ch();

  bm25_document_scorer_unit dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch),
    .cfg_ch(cfg_ch)
  );

  term_t       pending_terms[$];
  doc_score_t  score_fifo[$];
  term_t       cur_term;
  logic [63:0] log_tab[0:(1 << TB)];
  logic [63:0] n_docs, avg_len, k1, b_weight;
  logic [63:0] acc_sum;
  logic        acc_ovf;
  int          errors = 0;
  int          gap = 0;
  int          burst = 0;
  int          rdy_mode = 0;
  int          rdy_left = 0;
  int          stall_left = 0;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // log2(1 + i/2^TB) in Q0.FB by squaring the mantissa
  initial begin
    logic [63:0] m;
    logic [63:0] r;
    for (int i = 0; i <= (1 << TB); i++) begin
      if (i == (1 << TB)) begin
        log_tab[i] = 64'd1 << FB;
      end else begin
        m = ((64'd1 << TB) + 64'(i)) << (30 - TB);
        r = 64'd0;
        for (int k = 0; k < FB; k++) begin
          m = (m * m) >> 30;
          r = r << 1;
          if (m >= 64'h8000_0000) begin
            r = r | 64'd1;
            m = m >> 1;
          end
        end
        log_tab[i] = r;
      end
    end
  end

  function automatic logic [63:0] log2_q(logic [63:0] x);
    int e;
    logic [63:0] f, idx, rem, lo, hi;
    e = 0;
    if (x == 64'd0) x = 64'd1;
    while (e < 63 && (x >> (e + 1)) != 64'd0) e++;
    f = x - (64'd1 << e);
    if (e <= 32) f = f << (32 - e);
    else f = f >> (e - 32);
    f = f & 64'hFFFF_FFFF;
    idx = f >> (32 - TB);
    rem = f & ((64'd1 << (32 - TB)) - 64'd1);
    lo = log_tab[idx];
    hi = log_tab[idx + 1];
    return (64'(e) << FB) + lo + (((hi - lo) * rem) >> (32 - TB));
  endfunction

  function automatic logic [63:0] ln_q(logic [63:0] x);
    return (log2_q(x) * 64'(LN2_Q32) + (64'd1 << 31)) >> 32;
  endfunction

  // add one term to the running document score, queue the score on the last term
  function void score_term(term_t t);
    logic [63:0] avg, b, ln_num, ln_den, idf, q, rm, ratio, inner, norm, tfq, den, frac, w;
    doc_score_t ds;
    avg = (avg_len == 64'd0) ? 64'd1 : avg_len;
    b = (b_weight > 64'd4096) ? 64'd4096 : b_weight;
    ln_num = ln_q(2 * n_docs + 2);
    ln_den = ln_q(2 * 64'(t.df) + 1);
    idf = (ln_num > ln_den) ? ln_num - ln_den : 64'd0;
    q = (64'(t.len) << 16) / avg;
    rm = (64'(t.len) << 16) % avg;
    if (q >= (64'd1 << 24)) ratio = RATIO_TOP;
    else ratio = (q << FB) + ((rm << FB) / avg);
    inner = (((64'd4096 - b) << FB) + b * ratio) >> 12;
    norm = (k1 * inner) >> 12;
    tfq = 64'(t.tf) << FB;
    den = tfq + norm;
    frac = (den != 64'd0) ? ((tfq << 20) / den) : 64'd0;
    w = (((idf * (k1 + 64'd4096)) >> 12) * frac) >> 20;
    acc_sum = acc_sum + w;
    if (acc_sum > ACC_TOP) begin
      acc_sum = ACC_TOP;
      acc_ovf = 1'b1;
    end
    if (t.last) begin
      if (acc_sum > 64'hFFFF_FFFF) begin
        ds.score = 32'hFFFF_FFFF;
        ds.sat = 1'b1;
      end else begin
        ds.score = acc_sum[31:0];
        ds.sat = acc_ovf;
      end
      score_fifo = {score_fifo, ds};
      acc_sum = 64'd0;
      acc_ovf = 1'b0;
    end
  endfunction

  // sender: bursts of words with random gaps
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      gap = 0;
    end else begin
      if (in_ch.valid && in_ch.ready) score_term(cur_term);
      if (!in_ch.valid || in_ch.ready) begin
        if (gap > 0) begin
          gap--;
          in_ch.valid <= 1'b0;
        end else if (pending_terms.size() > 0) begin
          cur_term = pending_terms.pop_front();
          in_ch.valid <= 1'b1;
          in_ch.term_count <= cur_term.tf;
          in_ch.docs_with_term <= cur_term.df;
          in_ch.document_length <= cur_term.len;
          in_ch.last_term <= cur_term.last;
          burst--;
          if (burst <= 0) begin
            burst = $urandom_range(1, 30);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 120);
          end
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // receiver: ready follows a mode that changes every so often
  always @(posedge clk) begin
    if (rdy_left == 0) begin
      rdy_mode = $urandom_range(0, 2);
      rdy_left = $urandom_range(50, 2000);
    end
    rdy_left--;
    case (rdy_mode)
      0: out_ch.ready <= 1'b1;
      1: out_ch.ready <= 1'($urandom_range(0, 1));
      default: begin
        if (stall_left > 0) begin
          stall_left--;
          out_ch.ready <= 1'b0;
        end else begin
          out_ch.ready <= 1'b1;
          if ($urandom_range(0, 3) == 0) stall_left = $urandom_range(1, 200);
        end
      end
    endcase
  end

  always @(posedge clk) begin
    doc_score_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (score_fifo.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected score word %h sat %b",
                                   out_ch.score, out_ch.score_saturated);
      end else begin
        want = score_fifo.pop_front();
        if (out_ch.score !== want.score || out_ch.score_saturated !== want.sat) begin
          errors++;
          if (errors <= 10)
            $display("score mismatch: expected %h sat %b, got %h sat %b",
                     want.score, want.sat, out_ch.score, out_ch.score_saturated);
        end
      end
    end
  end

  task automatic write_reg(cfg_index_t idx, logic [31:0] v);
    @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= v;
    do @(posedge clk); while (!cfg_ch.ready);
    case (idx)
      CFG_DOC_COUNT: n_docs = 64'(v);
      CFG_AVG_LEN:   avg_len = 64'(v);
      CFG_K1:        k1 = 64'(v[15:0]);
      CFG_B:         b_weight = 64'(v[12:0]);
    endcase
    cfg_ch.valid <= 1'b0;
  endtask

  // hold until every word is sent and scored, then let the block settle
  task automatic drain();
    while (pending_terms.size() != 0 || in_ch.valid || score_fifo.size() != 0)
      @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic add_term(logic [15:0] tf, logic [31:0] df, logic [23:0] len, logic last);
    term_t t;
    t.tf = tf;
    t.df = df;
    t.len = len;
    t.last = last;
    pending_terms = {pending_terms, t};
  endtask

  function automatic logic [31:0] pick_df();
    case ($urandom_range(0, 5))
      0: return 32'd0;
      1: return 32'hFFFF_FFFF;
      2: return n_docs[31:0];
      3: return $urandom();
      default: return (n_docs == 0) ? $urandom_range(0, 3) : $urandom_range(0, n_docs[31:0]);
    endcase
  endfunction

  function automatic logic [15:0] pick_tf();
    case ($urandom_range(0, 5))
      0: return 16'd0;
      1: return 16'hFFFF;
      2: return 16'($urandom());
      default: return 16'($urandom_range(1, 12));
    endcase
  endfunction

  function automatic logic [23:0] pick_len();
    case ($urandom_range(0, 5))
      0: return 24'd0;
      1: return 24'hFF_FFFF;
      2: return 24'($urandom());
      default: return 24'($urandom_range(1, 3000));
    endcase
  endfunction

  task automatic add_docs(int n_items, int max_terms);
    int done;
    int nt;
    logic [23:0] len;
    done = 0;
    while (done < n_items) begin
      nt = $urandom_range(1, max_terms);
      len = pick_len();
      for (int i = 0; i < nt; i++) begin
        // most terms share the document length, a few do not
        add_term(pick_tf(), pick_df(), ($urandom_range(0, 7) == 0) ? pick_len() : len,
                 i == nt - 1);
      end
      done += nt;
    end
  endtask

  initial begin
    logic [31:0] v;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.term_count = '0;
    in_ch.docs_with_term = '0;
    in_ch.document_length = '0;
    in_ch.last_term = 1'b0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = CFG_DOC_COUNT;
    cfg_ch.data = '0;
    n_docs = 64'(DOC_COUNT_RST);
    avg_len = 64'(AVG_LEN_RST);
    k1 = 64'(K1_RST);
    b_weight = 64'(B_RST);
    acc_sum = 64'd0;
    acc_ovf = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // defaults from reset
    add_term(16'd3, 32'd0, 24'd100, 1'b1);
    add_term(16'hFFFF, 32'hFFFF_FFFF, 24'hFF_FFFF, 1'b0);
    add_term(16'd0, 32'd0, 24'd0, 1'b1);
    drain();

    // zero average length, b above one, zero denominator, huge ratio, df above N
    write_reg(CFG_DOC_COUNT, 32'd1000);
    write_reg(CFG_AVG_LEN, 32'd0);
    write_reg(CFG_K1, 32'd4915);
    write_reg(CFG_B, 32'd8191);
    add_term(16'd0, 32'd10, 24'd0, 1'b1);
    add_term(16'd5, 32'd10, 24'hFF_FFFF, 1'b1);
    add_term(16'd5, 32'd5000, 24'd10, 1'b1);
    add_term(16'hFFFF, 32'd0, 24'd1, 1'b0);
    add_term(16'd1, 32'd1000, 24'd7, 1'b0);
    add_term(16'd2, 32'd999, 24'd7, 1'b1);
    drain();

    // large idf and k1: long documents clip the score
    write_reg(CFG_DOC_COUNT, 32'hFFFF_FFFF);
    write_reg(CFG_AVG_LEN, 32'hFFFF_FFFF);
    write_reg(CFG_K1, 32'hFFFF);
    write_reg(CFG_B, 32'd0);
    for (int d = 0; d < 2; d++)
      for (int i = 0; i < 200; i++) add_term(16'hFFFF, 32'd0, 24'd5, i == 199);
    add_docs(20, 6);
    drain();

    for (int ph = 0; ph < 10; ph++) begin
      case ($urandom_range(0, 3))
        0: v = 32'd0;
        1: v = 32'hFFFF_FFFF;
        2: v = $urandom_range(1, 100000);
        default: v = $urandom();
      endcase
      write_reg(CFG_DOC_COUNT, v);
      case ($urandom_range(0, 4))
        0: v = 32'd0;
        1: v = 32'd1;
        2: v = 32'hFFFF_FFFF;
        3: v = $urandom_range(50, 3000) << 16;
        default: v = $urandom();
      endcase
      write_reg(CFG_AVG_LEN, v);
      case ($urandom_range(0, 3))
        0: v = 32'd0;
        1: v = 32'hFFFF;
        2: v = $urandom_range(2048, 12288);
        default: v = $urandom_range(0, 65535);
      endcase
      write_reg(CFG_K1, v);
      case ($urandom_range(0, 4))
        0: v = 32'd0;
        1: v = 32'd4096;
        2: v = $urandom_range(4097, 8191);
        default: v = $urandom_range(0, 4096);
      endcase
      write_reg(CFG_B, v);
      add_docs(55, 8);
      drain();
    end

    if (score_fifo.size() != 0) errors++;
    if (errors == 0) begin
      $display("bm25_document_scorer_unit_test passed");
    end else begin
      $display("bm25_document_scorer_unit_test failed");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("bm25_document_scorer_unit_test failed");
    $finish;
  end

endmodule
